// File: hdl/cpu65_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_pkg
// Shared types, constants and the opcode decoder for the 6502 subset
// executor.
// ----------------------------------------------------------------------------
package cpu65_pkg;

    localparam int AddrBitsDef = 16;

    localparam logic [7:0] SpReset  = 8'hFD;
    localparam logic [7:0] Bit7Mask = 8'h80;
    localparam logic [7:0] Bit0Mask = 8'h01;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SETPC = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        OP_NONE, OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_LDX, OP_LDY, OP_STA,
        OP_STX, OP_STY, OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_TAX, OP_TAY,
        OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } t_op;

    typedef enum logic [3:0] {
        M_IMP, M_ACC, M_IMM, M_ZPG, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
        M_IDX, M_IDY
    } t_mode;

    typedef struct packed {
        t_op        op;
        t_mode      mode;
        logic [2:0] cyc;
    } t_dec;

    // Architectural register file as seen by the execution logic.
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic       n;
        logic       z;
        logic       c;
    } t_arch;

    typedef struct packed {
        t_arch      regs;
        logic       we;
        logic [7:0] wdata;
    } t_alu_res;

    function automatic t_dec mk_dec(t_op op, t_mode mode, logic [2:0] cyc);
        t_dec d;
        d.op   = op;
        d.mode = mode;
        d.cyc  = cyc;
        return d;
    endfunction

    function automatic t_dec decode_op(logic [7:0] b);
        logic [1:0] grp;
        logic [2:0] aaa;
        logic [2:0] bbb;
        t_op        op;
        t_mode      mode;
        logic [2:0] rcyc;
        logic [2:0] scyc;
        t_dec       d;
        grp  = b[1:0];
        aaa  = b[7:5];
        bbb  = b[4:2];
        d    = mk_dec(OP_NONE, M_IMP, 3'd0);
        op   = OP_NONE;
        mode = M_IMP;
        rcyc = 3'd0;
        scyc = 3'd0;
        if (grp == 2'd1) begin
            case (aaa)
                3'd0:    op = OP_ORA;
                3'd1:    op = OP_AND;
                3'd2:    op = OP_EOR;
                3'd4:    op = OP_STA;
                3'd5:    op = OP_LDA;
                default: op = OP_NONE;
            endcase
            case (bbb)
                3'd0:    begin mode = M_IDX; rcyc = 3'd6; scyc = 3'd6; end
                3'd1:    begin mode = M_ZPG; rcyc = 3'd3; scyc = 3'd3; end
                3'd2:    begin mode = M_IMM; rcyc = 3'd2; scyc = 3'd0; end
                3'd3:    begin mode = M_ABS; rcyc = 3'd4; scyc = 3'd4; end
                3'd4:    begin mode = M_IDY; rcyc = 3'd5; scyc = 3'd6; end
                3'd5:    begin mode = M_ZPX; rcyc = 3'd4; scyc = 3'd4; end
                3'd6:    begin mode = M_ABY; rcyc = 3'd4; scyc = 3'd5; end
                default: begin mode = M_ABX; rcyc = 3'd4; scyc = 3'd5; end
            endcase
            if (op == OP_NONE || (op == OP_STA && bbb == 3'd2)) begin
                d = mk_dec(OP_NONE, M_IMP, 3'd0);
            end else begin
                d = mk_dec(op, mode, (op == OP_STA) ? scyc : rcyc);
            end
        end else if (grp == 2'd2 && !aaa[2]) begin
            case (aaa[1:0])
                2'd0:    op = OP_ASL;
                2'd1:    op = OP_ROL;
                2'd2:    op = OP_LSR;
                default: op = OP_ROR;
            endcase
            case (bbb)
                3'd1:    d = mk_dec(op, M_ZPG, 3'd5);
                3'd2:    d = mk_dec(op, M_ACC, 3'd2);
                3'd3:    d = mk_dec(op, M_ABS, 3'd6);
                3'd5:    d = mk_dec(op, M_ZPX, 3'd6);
                3'd7:    d = mk_dec(op, M_ABX, 3'd7);
                default: d = mk_dec(OP_NONE, M_IMP, 3'd0);
            endcase
        end else begin
            case (b)
                8'hA2:   d = mk_dec(OP_LDX, M_IMM, 3'd2);
                8'hA6:   d = mk_dec(OP_LDX, M_ZPG, 3'd3);
                8'hB6:   d = mk_dec(OP_LDX, M_ZPY, 3'd4);
                8'hAE:   d = mk_dec(OP_LDX, M_ABS, 3'd4);
                8'hBE:   d = mk_dec(OP_LDX, M_ABY, 3'd4);
                8'hA0:   d = mk_dec(OP_LDY, M_IMM, 3'd2);
                8'hA4:   d = mk_dec(OP_LDY, M_ZPG, 3'd3);
                8'hB4:   d = mk_dec(OP_LDY, M_ZPX, 3'd4);
                8'hAC:   d = mk_dec(OP_LDY, M_ABS, 3'd4);
                8'hBC:   d = mk_dec(OP_LDY, M_ABX, 3'd4);
                8'h86:   d = mk_dec(OP_STX, M_ZPG, 3'd3);
                8'h96:   d = mk_dec(OP_STX, M_ZPY, 3'd4);
                8'h8E:   d = mk_dec(OP_STX, M_ABS, 3'd4);
                8'h84:   d = mk_dec(OP_STY, M_ZPG, 3'd3);
                8'h94:   d = mk_dec(OP_STY, M_ZPX, 3'd4);
                8'h8C:   d = mk_dec(OP_STY, M_ABS, 3'd4);
                8'hAA:   d = mk_dec(OP_TAX, M_IMP, 3'd2);
                8'hA8:   d = mk_dec(OP_TAY, M_IMP, 3'd2);
                8'hBA:   d = mk_dec(OP_TSX, M_IMP, 3'd2);
                8'h8A:   d = mk_dec(OP_TXA, M_IMP, 3'd2);
                8'h9A:   d = mk_dec(OP_TXS, M_IMP, 3'd2);
                8'h98:   d = mk_dec(OP_TYA, M_IMP, 3'd2);
                default: d = mk_dec(OP_NONE, M_IMP, 3'd0);
            endcase
        end
        return d;
    endfunction

    function automatic logic [15:0] mode_len(t_mode m);
        logic [15:0] len;
        case (m)
            M_IMP, M_ACC:       len = 16'd1;
            M_ABS, M_ABX, M_ABY: len = 16'd3;
            default:            len = 16'd2;
        endcase
        return len;
    endfunction

    function automatic logic is_store(t_op op);
        return (op == OP_STA) || (op == OP_STX) || (op == OP_STY);
    endfunction

    function automatic logic is_read(t_op op);
        return (op == OP_AND) || (op == OP_ORA) || (op == OP_EOR) ||
               (op == OP_LDA) || (op == OP_LDX) || (op == OP_LDY);
    endfunction

endpackage

// File: hdl/cpu6502_subset_execute.sv
`timescale 1ns / 1ps
// Sequence: a host write or set-PC goes from S_IDLE straight to S_DONE, a host read passes
// through S_HRD, an unsupported opcode through S_OPC; an instruction takes one state per memory
// byte read through the single read port, then S_EXE, and S_DONE loads the output register.
// Flow: one beat in flight, the next taken the cycle after the result is loaded; a result may
// wait in the output register while the next runs.
// Reset (synchronous, active low) clears A, X, Y, PC and flags, sets SP to 0xFD; memory kept.
// ----------------------------------------------------------------------------
// cpu6502_subset_execute
// Executes a subset of 6502 instructions out of a local byte memory, and
// lets a host write, read the memory and set the program counter.
// ----------------------------------------------------------------------------
module cpu6502_subset_execute
    import cpu65_pkg::*;
#(
    parameter int ADDR_BITS = AddrBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_host_address,
    input  logic [7:0]  i_host_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_accumulator,
    output logic [7:0]  o_index_x,
    output logic [7:0]  o_index_y,
    output logic [7:0]  o_stack_pointer,
    output logic [15:0] o_program_counter,
    output logic        o_negative_flag,
    output logic        o_zero_flag,
    output logic        o_carry_flag,
    output logic [2:0]  o_cycle_count,
    output logic [7:0]  o_read_data,
    output logic        o_unsupported
);

    localparam int MemDepth = 1 << ADDR_BITS;

    // Sequencer states. Each read state consumes the byte requested in the
    // state before, since the memory read is registered.
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_OPC  = 10'b0000000010,
        S_OP1  = 10'b0000000100,
        S_OP2  = 10'b0000001000,
        S_PLO  = 10'b0000010000,
        S_PHI  = 10'b0000100000,
        S_DAT  = 10'b0001000000,
        S_EXE  = 10'b0010000000,
        S_HRD  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state      r_state, n_state;
    t_arch       r_regs, n_regs;
    logic [15:0] r_pc, n_pc;
    t_dec        r_dec, n_dec;
    logic [15:0] r_ea, n_ea;
    logic [7:0]  r_op1, n_op1;
    logic [7:0]  r_plo, n_plo;
    logic [7:0]  r_val, n_val;
    logic        r_cross, n_cross;
    logic [2:0]  r_cyc, n_cyc;
    logic        r_unsup, n_unsup;
    logic [7:0]  r_rdata, n_rdata;
    logic        r_out_valid;

    logic [15:0] raddr;
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic [7:0]  rd_data;

    t_dec        dec_now;
    t_alu_res    alu_res;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [15:0] sum;
    logic        accept;
    logic        out_free;

    cpu65_ram #(
        .WIDTH (8),
        .DEPTH (MemDepth)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[ADDR_BITS-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[ADDR_BITS-1:0]),
        .o_rdata (rd_data)
    );

    cpu65_alu u_alu (
        .i_op   (r_dec.op),
        .i_mode (r_dec.mode),
        .i_val  (r_val),
        .i_regs (r_regs),
        .o_res  (alu_res)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign dec_now    = decode_op(rd_data);

    // Indexed address: base is the operand pair (absolute modes) or the
    // pointer pair (indirect modes); the sum wraps at 16 bits.
    always_comb begin
        base = {rd_data, (r_state == S_OP2) ? r_op1 : r_plo};
        case (r_dec.mode)
            M_ABX:        idx = r_regs.x;
            M_ABY, M_IDY: idx = r_regs.y;
            default:      idx = 8'h00;
        endcase
        sum = base + {8'h00, idx};
    end

    always_comb begin
        n_state = r_state;
        n_regs  = r_regs;
        n_pc    = r_pc;
        n_dec   = r_dec;
        n_ea    = r_ea;
        n_op1   = r_op1;
        n_plo   = r_plo;
        n_val   = r_val;
        n_cross = r_cross;
        n_cyc   = r_cyc;
        n_unsup = r_unsup;
        n_rdata = r_rdata;
        raddr   = r_pc;
        we      = 1'b0;
        waddr   = i_host_address;
        wdata   = i_host_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cyc   = 3'd0;
                    n_unsup = 1'b0;
                    n_rdata = 8'h00;
                    n_cross = 1'b0;
                    case (t_cmd'(i_cmd))
                        CMD_EXEC: begin
                            raddr   = r_pc;
                            n_state = S_OPC;
                        end
                        CMD_WRITE: begin
                            we      = 1'b1;
                            n_state = S_DONE;
                        end
                        CMD_READ: begin
                            raddr   = i_host_address;
                            n_state = S_HRD;
                        end
                        default: begin
                            n_pc    = i_host_address;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_OPC: begin
                n_dec = dec_now;
                if (dec_now.op == OP_NONE) begin
                    n_unsup = 1'b1;
                    n_state = S_DONE;
                end else if (dec_now.mode == M_IMP || dec_now.mode == M_ACC) begin
                    n_state = S_EXE;
                end else begin
                    raddr   = r_pc + 16'd1;
                    n_state = S_OP1;
                end
            end
            S_OP1: begin
                n_op1 = rd_data;
                case (r_dec.mode)
                    M_IMM: begin
                        n_val   = rd_data;
                        n_state = S_EXE;
                    end
                    M_ZPG, M_ZPX, M_ZPY: begin
                        if (r_dec.mode == M_ZPX) begin
                            n_ea = {8'h00, rd_data + r_regs.x};
                        end else if (r_dec.mode == M_ZPY) begin
                            n_ea = {8'h00, rd_data + r_regs.y};
                        end else begin
                            n_ea = {8'h00, rd_data};
                        end
                        raddr   = n_ea;
                        n_state = is_store(r_dec.op) ? S_EXE : S_DAT;
                    end
                    M_IDX, M_IDY: begin
                        n_ea    = {8'h00, (r_dec.mode == M_IDX) ? rd_data + r_regs.x
                                                               : rd_data};
                        raddr   = n_ea;
                        n_state = S_PLO;
                    end
                    default: begin
                        raddr   = r_pc + 16'd2;
                        n_state = S_OP2;
                    end
                endcase
            end
            S_PLO: begin
                // The pointer's high byte stays on page zero.
                n_plo   = rd_data;
                raddr   = {8'h00, r_ea[7:0] + 8'd1};
                n_state = S_PHI;
            end
            S_OP2, S_PHI: begin
                n_ea    = sum;
                n_cross = (sum[15:8] != base[15:8]);
                raddr   = sum;
                n_state = is_store(r_dec.op) ? S_EXE : S_DAT;
            end
            S_DAT: begin
                n_val   = rd_data;
                n_state = S_EXE;
            end
            S_EXE: begin
                n_regs  = alu_res.regs;
                we      = alu_res.we;
                waddr   = r_ea;
                wdata   = alu_res.wdata;
                n_pc    = r_pc + mode_len(r_dec.mode);
                n_cyc   = r_dec.cyc + {2'b00, r_cross && is_read(r_dec.op)};
                n_state = S_DONE;
            end
            S_HRD: begin
                n_rdata = rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_regs      <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SpReset,
                             n: 1'b0, z: 1'b0, c: 1'b0};
            r_pc        <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_regs  <= n_regs;
            r_pc    <= n_pc;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec   <= n_dec;
        r_ea    <= n_ea;
        r_op1   <= n_op1;
        r_plo   <= n_plo;
        r_val   <= n_val;
        r_cross <= n_cross;
        r_cyc   <= n_cyc;
        r_unsup <= n_unsup;
        r_rdata <= n_rdata;
    end

    // Output register: loaded only when the previous beat has been taken.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_accumulator     <= r_regs.a;
            o_index_x         <= r_regs.x;
            o_index_y         <= r_regs.y;
            o_stack_pointer   <= r_regs.sp;
            o_program_counter <= r_pc;
            o_negative_flag   <= r_regs.n;
            o_zero_flag       <= r_regs.z;
            o_carry_flag      <= r_regs.c;
            o_cycle_count     <= r_cyc;
            o_read_data       <= r_rdata;
            o_unsupported     <= r_unsup;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/cpu65_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cpu65_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: hdl/cpu65_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_alu
// Result logic: logic operations, loads, stores, shifts and transfers.
// ----------------------------------------------------------------------------
module cpu65_alu
    import cpu65_pkg::*;
(
    input  t_op        i_op,
    input  t_mode      i_mode,
    input  logic [7:0] i_val,
    input  t_arch      i_regs,
    output t_alu_res   o_res
);

    logic [7:0] v;
    logic [7:0] r;
    t_alu_res   res;

    always_comb begin
        res       = '0;
        res.regs  = i_regs;
        res.we    = 1'b0;
        res.wdata = 8'h00;
        v         = (i_mode == M_ACC) ? i_regs.a : i_val;
        r         = 8'h00;
        case (i_op)
            OP_AND: r = i_regs.a & v;
            OP_ORA: r = i_regs.a | v;
            OP_EOR: r = i_regs.a ^ v;
            OP_ASL: r = {v[6:0], 1'b0};
            OP_ROL: r = {v[6:0], i_regs.c};
            OP_LSR: r = {1'b0, v[7:1]};
            OP_ROR: r = {i_regs.c, v[7:1]};
            OP_TAX, OP_TAY: r = i_regs.a;
            OP_TSX: r = i_regs.sp;
            OP_TXA: r = i_regs.x;
            OP_TYA: r = i_regs.y;
            default: r = v;
        endcase
        case (i_op)
            OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_TXA, OP_TYA: res.regs.a = r;
            OP_LDX, OP_TAX, OP_TSX: res.regs.x = r;
            OP_LDY, OP_TAY: res.regs.y = r;
            OP_TXS: res.regs.sp = i_regs.x;
            OP_STA: begin res.we = 1'b1; res.wdata = i_regs.a; end
            OP_STX: begin res.we = 1'b1; res.wdata = i_regs.x; end
            OP_STY: begin res.we = 1'b1; res.wdata = i_regs.y; end
            OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                if (i_mode == M_ACC) begin
                    res.regs.a = r;
                end else begin
                    res.we    = 1'b1;
                    res.wdata = r;
                end
                res.regs.c = (i_op == OP_ASL || i_op == OP_ROL) ?
                             ((v & Bit7Mask) != 8'h00) : ((v & Bit0Mask) != 8'h00);
            end
            default: ;
        endcase
        // Stores, TXS and OP_NONE leave the flags alone; everything else sets N and Z.
        if (!(is_store(i_op) || i_op == OP_TXS || i_op == OP_NONE)) begin
            res.regs.n = r[7];
            res.regs.z = (r == 8'h00);
        end
        o_res = res;
    end

endmodule

// File: hdl/cpu65_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_checker
// Port-level checks on the result stream of the 6502 subset executor.
// ----------------------------------------------------------------------------
module cpu65_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_cycle_count,
    input logic [7:0] o_read_data,
    input logic       o_unsupported
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_unsup_no_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unsupported |-> o_cycle_count == 3'd0 && o_read_data == 8'h00)
        else $error("unsupported opcode reported cycles or read data");

    a_read_not_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_data != 8'h00 |-> o_cycle_count == 3'd0)
        else $error("read data on an executed instruction");

    a_min_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cycle_count != 3'd0 |-> o_cycle_count != 3'd1)
        else $error("instruction reported a single cycle");

endmodule

bind cpu6502_subset_execute cpu65_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cycle_count (o_cycle_count),
    .o_read_data   (o_read_data),
    .o_unsupported (o_unsupported)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 6502 subset executor. A scoreboard class keeps
// its own copy of the registers, the flags and the byte memory. It works out
// the result of every accepted input beat and compares it with the output
// beats in order. Before an instruction runs, host writes fill every byte that
// it will fetch or read, so no unwritten byte is ever read.
// ----------------------------------------------------------------------------

typedef struct {
    bit [7:0]  acc;
    bit [7:0]  x;
    bit [7:0]  y;
    bit [7:0]  sp;
    bit [15:0] pc;
    bit        n;
    bit        z;
    bit        c;
    bit [2:0]  cyc;
    bit [7:0]  rdata;
    bit        unsup;
} cpu_beat_t;

class cpu_scoreboard;
    bit [7:0]  mem [65536];
    bit        written [65536];
    bit [15:0] written_list [$];
    bit [7:0]  a, x, y, sp;
    bit [15:0] pc;
    bit        n, z, c;
    cpu_beat_t pending [$];
    int        errors, n_exec, n_unsup, n_cross, n_host;

    function new();
        sp = cpu65_pkg::SpReset;
    endfunction

    function void store(bit [15:0] addr, bit [7:0] v);
        mem[addr] = v;
        if (!written[addr]) begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
        end
    endfunction

    function void set_nz(bit [7:0] v);
        n = v[7];
        z = (v == 8'h00);
    endfunction

    // Opcode map: the ALU column (low bits 01), the shift column (low bits
    // 10, top bit clear) and a short list of index loads, stores and moves.
    function void decode(bit [7:0] b, output cpu65_pkg::t_op op,
                         output cpu65_pkg::t_mode mode, output int cyc);
        cpu65_pkg::t_mode alu_mode [8] = '{cpu65_pkg::M_IDX, cpu65_pkg::M_ZPG,
            cpu65_pkg::M_IMM, cpu65_pkg::M_ABS, cpu65_pkg::M_IDY,
            cpu65_pkg::M_ZPX, cpu65_pkg::M_ABY, cpu65_pkg::M_ABX};
        int load_cyc [8] = '{6, 3, 2, 4, 5, 4, 4, 4};
        int store_cyc [8] = '{6, 3, 0, 4, 6, 4, 5, 5};
        bit [2:0] hi, mid;
        hi = b[7:5];
        mid = b[4:2];
        op = cpu65_pkg::OP_NONE;
        mode = cpu65_pkg::M_IMP;
        cyc = 0;
        if (b[1:0] == 2'd1) begin
            case (hi)
                3'd0: op = cpu65_pkg::OP_ORA;
                3'd1: op = cpu65_pkg::OP_AND;
                3'd2: op = cpu65_pkg::OP_EOR;
                3'd4: op = cpu65_pkg::OP_STA;
                3'd5: op = cpu65_pkg::OP_LDA;
                default: op = cpu65_pkg::OP_NONE;
            endcase
            if (op == cpu65_pkg::OP_STA && mid == 3'd2) op = cpu65_pkg::OP_NONE;
            if (op != cpu65_pkg::OP_NONE) begin
                mode = alu_mode[mid];
                cyc = (op == cpu65_pkg::OP_STA) ? store_cyc[mid] : load_cyc[mid];
            end
        end else if (b[1:0] == 2'd2 && !hi[2]) begin
            case (mid)
                3'd1: begin mode = cpu65_pkg::M_ZPG; cyc = 5; end
                3'd2: begin mode = cpu65_pkg::M_ACC; cyc = 2; end
                3'd3: begin mode = cpu65_pkg::M_ABS; cyc = 6; end
                3'd5: begin mode = cpu65_pkg::M_ZPX; cyc = 6; end
                3'd7: begin mode = cpu65_pkg::M_ABX; cyc = 7; end
                default: cyc = 0;
            endcase
            if (cyc != 0) begin
                case (hi[1:0])
                    2'd0: op = cpu65_pkg::OP_ASL;
                    2'd1: op = cpu65_pkg::OP_ROL;
                    2'd2: op = cpu65_pkg::OP_LSR;
                    default: op = cpu65_pkg::OP_ROR;
                endcase
            end
        end else begin
            case (b)
                8'hA2: begin op = cpu65_pkg::OP_LDX; mode = cpu65_pkg::M_IMM; cyc = 2; end
                8'hA6: begin op = cpu65_pkg::OP_LDX; mode = cpu65_pkg::M_ZPG; cyc = 3; end
                8'hB6: begin op = cpu65_pkg::OP_LDX; mode = cpu65_pkg::M_ZPY; cyc = 4; end
                8'hAE: begin op = cpu65_pkg::OP_LDX; mode = cpu65_pkg::M_ABS; cyc = 4; end
                8'hBE: begin op = cpu65_pkg::OP_LDX; mode = cpu65_pkg::M_ABY; cyc = 4; end
                8'hA0: begin op = cpu65_pkg::OP_LDY; mode = cpu65_pkg::M_IMM; cyc = 2; end
                8'hA4: begin op = cpu65_pkg::OP_LDY; mode = cpu65_pkg::M_ZPG; cyc = 3; end
                8'hB4: begin op = cpu65_pkg::OP_LDY; mode = cpu65_pkg::M_ZPX; cyc = 4; end
                8'hAC: begin op = cpu65_pkg::OP_LDY; mode = cpu65_pkg::M_ABS; cyc = 4; end
                8'hBC: begin op = cpu65_pkg::OP_LDY; mode = cpu65_pkg::M_ABX; cyc = 4; end
                8'h86: begin op = cpu65_pkg::OP_STX; mode = cpu65_pkg::M_ZPG; cyc = 3; end
                8'h96: begin op = cpu65_pkg::OP_STX; mode = cpu65_pkg::M_ZPY; cyc = 4; end
                8'h8E: begin op = cpu65_pkg::OP_STX; mode = cpu65_pkg::M_ABS; cyc = 4; end
                8'h84: begin op = cpu65_pkg::OP_STY; mode = cpu65_pkg::M_ZPG; cyc = 3; end
                8'h94: begin op = cpu65_pkg::OP_STY; mode = cpu65_pkg::M_ZPX; cyc = 4; end
                8'h8C: begin op = cpu65_pkg::OP_STY; mode = cpu65_pkg::M_ABS; cyc = 4; end
                8'hAA: begin op = cpu65_pkg::OP_TAX; cyc = 2; end
                8'hA8: begin op = cpu65_pkg::OP_TAY; cyc = 2; end
                8'hBA: begin op = cpu65_pkg::OP_TSX; cyc = 2; end
                8'h8A: begin op = cpu65_pkg::OP_TXA; cyc = 2; end
                8'h9A: begin op = cpu65_pkg::OP_TXS; cyc = 2; end
                8'h98: begin op = cpu65_pkg::OP_TYA; cyc = 2; end
                default: op = cpu65_pkg::OP_NONE;
            endcase
        end
    endfunction

    // Works out the addresses the next instruction reads, in fetch order.
    function void plan(ref bit [15:0] reads [$], output cpu65_pkg::t_op op,
                       output cpu65_pkg::t_mode mode, output int cyc,
                       output bit [15:0] ea, output bit crossed,
                       output bit [15:0] next_pc);
        bit [15:0] p1, p2, base;
        bit [7:0]  b1, b2, zp, zp1;
        reads.delete();
        reads.push_back(pc);
        decode(mem[pc], op, mode, cyc);
        crossed = 1'b0;
        ea = 16'h0000;
        next_pc = pc;
        if (op == cpu65_pkg::OP_NONE) return;
        p1 = pc + 16'd1;
        p2 = pc + 16'd2;
        b1 = mem[p1];
        b2 = mem[p2];
        base = {b2, b1};
        next_pc = pc + 16'd2;
        case (mode)
            cpu65_pkg::M_IMP, cpu65_pkg::M_ACC: next_pc = pc + 16'd1;
            cpu65_pkg::M_IMM: begin reads.push_back(p1); ea = p1; end
            cpu65_pkg::M_ZPG: begin reads.push_back(p1); ea = {8'h00, b1}; end
            cpu65_pkg::M_ZPX: begin
                reads.push_back(p1);
                zp = b1 + x;
                ea = {8'h00, zp};
            end
            cpu65_pkg::M_ZPY: begin
                reads.push_back(p1);
                zp = b1 + y;
                ea = {8'h00, zp};
            end
            cpu65_pkg::M_IDX, cpu65_pkg::M_IDY: begin
                reads.push_back(p1);
                zp = (mode == cpu65_pkg::M_IDX) ? b1 + x : b1;
                zp1 = zp + 8'd1;
                reads.push_back({8'h00, zp});
                reads.push_back({8'h00, zp1});
                base = {mem[{8'h00, zp1}], mem[{8'h00, zp}]};
                ea = (mode == cpu65_pkg::M_IDY) ? base + {8'h00, y} : base;
                crossed = (mode == cpu65_pkg::M_IDY) && (ea[15:8] != base[15:8]);
            end
            default: begin
                reads.push_back(p1);
                reads.push_back(p2);
                next_pc = pc + 16'd3;
                if (mode == cpu65_pkg::M_ABX) ea = base + {8'h00, x};
                else if (mode == cpu65_pkg::M_ABY) ea = base + {8'h00, y};
                else ea = base;
                crossed = ea[15:8] != base[15:8];
            end
        endcase
        if (mode != cpu65_pkg::M_IMP && mode != cpu65_pkg::M_ACC &&
            op != cpu65_pkg::OP_STA && op != cpu65_pkg::OP_STX && op != cpu65_pkg::OP_STY)
            reads.push_back(ea);
    endfunction

    // Notes one accepted input beat and queues the result it must give.
    function void note(cpu65_pkg::t_cmd cmd, bit [15:0] addr, bit [7:0] data);
        cpu_beat_t        r;
        bit [15:0]        reads [$];
        cpu65_pkg::t_op   op;
        cpu65_pkg::t_mode mode;
        int               cyc;
        bit [15:0]        ea, next_pc;
        bit               crossed, cin, is_load;
        bit [7:0]         v, res;
        r = '{default: 0};
        case (cmd)
            cpu65_pkg::CMD_EXEC: begin
                plan(reads, op, mode, cyc, ea, crossed, next_pc);
                n_exec++;
                if (op == cpu65_pkg::OP_NONE) begin
                    r.unsup = 1'b1;
                    n_unsup++;
                end else begin
                    cin = c;
                    pc = next_pc;
                    is_load = 1'b0;
                    case (op)
                        cpu65_pkg::OP_AND: begin a = a & mem[ea]; set_nz(a); is_load = 1; end
                        cpu65_pkg::OP_ORA: begin a = a | mem[ea]; set_nz(a); is_load = 1; end
                        cpu65_pkg::OP_EOR: begin a = a ^ mem[ea]; set_nz(a); is_load = 1; end
                        cpu65_pkg::OP_LDA: begin a = mem[ea]; set_nz(a); is_load = 1; end
                        cpu65_pkg::OP_LDX: begin x = mem[ea]; set_nz(x); is_load = 1; end
                        cpu65_pkg::OP_LDY: begin y = mem[ea]; set_nz(y); is_load = 1; end
                        cpu65_pkg::OP_STA: store(ea, a);
                        cpu65_pkg::OP_STX: store(ea, x);
                        cpu65_pkg::OP_STY: store(ea, y);
                        cpu65_pkg::OP_TAX: begin x = a; set_nz(x); end
                        cpu65_pkg::OP_TAY: begin y = a; set_nz(y); end
                        cpu65_pkg::OP_TSX: begin x = sp; set_nz(x); end
                        cpu65_pkg::OP_TXA: begin a = x; set_nz(a); end
                        cpu65_pkg::OP_TXS: sp = x;
                        cpu65_pkg::OP_TYA: begin a = y; set_nz(a); end
                        default: begin
                            v = (mode == cpu65_pkg::M_ACC) ? a : mem[ea];
                            case (op)
                                cpu65_pkg::OP_ASL: res = {v[6:0], 1'b0};
                                cpu65_pkg::OP_ROL: res = {v[6:0], cin};
                                cpu65_pkg::OP_LSR: res = {1'b0, v[7:1]};
                                default:           res = {cin, v[7:1]};
                            endcase
                            if (mode == cpu65_pkg::M_ACC) a = res;
                            else store(ea, res);
                            set_nz(res);
                            c = (op == cpu65_pkg::OP_ASL || op == cpu65_pkg::OP_ROL) ?
                                v[7] : v[0];
                        end
                    endcase
                    if (crossed && is_load) begin
                        cyc++;
                        n_cross++;
                    end
                    r.cyc = cyc[2:0];
                end
            end
            cpu65_pkg::CMD_WRITE: begin store(addr, data); n_host++; end
            cpu65_pkg::CMD_READ:  begin r.rdata = mem[addr]; n_host++; end
            default:              begin pc = addr; n_host++; end
        endcase
        r.acc = a;
        r.x = x;
        r.y = y;
        r.sp = sp;
        r.pc = pc;
        r.n = n;
        r.z = z;
        r.c = c;
        pending.push_back(r);
    endfunction

    function void cmp(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endfunction

    function void check(cpu_beat_t got);
        cpu_beat_t want;
        if (pending.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
            return;
        end
        want = pending.pop_front();
        cmp("accumulator", want.acc, got.acc);
        cmp("index_x", want.x, got.x);
        cmp("index_y", want.y, got.y);
        cmp("stack_pointer", want.sp, got.sp);
        cmp("program_counter", want.pc, got.pc);
        cmp("negative_flag", want.n, got.n);
        cmp("zero_flag", want.z, got.z);
        cmp("carry_flag", want.c, got.c);
        cmp("cycle_count", want.cyc, got.cyc);
        cmp("read_data", want.rdata, got.rdata);
        cmp("unsupported", want.unsup, got.unsup);
    endfunction
endclass

module tb;
    import cpu65_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [15:0] i_host_address;
    logic [7:0]  i_host_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_accumulator;
    logic [7:0]  o_index_x;
    logic [7:0]  o_index_y;
    logic [7:0]  o_stack_pointer;
    logic [15:0] o_program_counter;
    logic        o_negative_flag;
    logic        o_zero_flag;
    logic        o_carry_flag;
    logic [2:0]  o_cycle_count;
    logic [7:0]  o_read_data;
    logic        o_unsupported;

    cpu_scoreboard sb;
    int  beats_sent;
    int  burst_left;
    int  idle_cycles;
    bit  hold_req;
    int  hold_left;
    int  stall_mode;
    int  mode_left;

    cpu6502_subset_execute dut (.*);

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches stall pattern on a counter: none at all, light,
    // heavy or alternating. A long hold-off request overrides it and runs
    // out on its own count.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 120;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(3);
            mode_left = 64;
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(3) == 0);
                2:       i_out_stall <= ($urandom_range(3) != 0);
                default: i_out_stall <= mode_left[0];
            endcase
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        cpu_beat_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.acc = o_accumulator;
            got.x = o_index_x;
            got.y = o_index_y;
            got.sp = o_stack_pointer;
            got.pc = o_program_counter;
            got.n = o_negative_flag;
            got.z = o_zero_flag;
            got.c = o_carry_flag;
            got.cyc = o_cycle_count;
            got.rdata = o_read_data;
            got.unsup = o_unsupported;
            sb.check(got);
        end
    end

    // Watchdog: a long run of cycles with no beat moving on either side means
    // the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles > 3000) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drops valid at the next falling edge; used before any wait that is not a send.
    task automatic quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Offers one beat and returns at the rising edge that takes it. The
    // sender runs in bursts of random length separated by random gaps.
    task automatic send(t_cmd cmd, bit [15:0] addr, bit [7:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) quiet();
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_host_address <= addr;
        i_host_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(cmd, addr, data);
        beats_sent++;
    endtask

    // Fills, one host write at a time, every byte the next instruction will
    // fetch or read that has never been written, then executes it. The plan
    // is worked out again after each write, since a pointer byte only gives
    // its target once it holds a value.
    task automatic run_instruction();
        bit [15:0]  reads [$];
        t_op        op;
        t_mode      mode;
        int         cyc;
        bit [15:0]  ea, next_pc;
        bit         crossed, filled;
        filled = 1'b0;
        while (!filled) begin
            sb.plan(reads, op, mode, cyc, ea, crossed, next_pc);
            filled = 1'b1;
            foreach (reads[i]) begin
                if (filled && !sb.written[reads[i]]) begin
                    send(CMD_WRITE, reads[i], 8'($urandom));
                    filled = 1'b0;
                end
            end
        end
        send(CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // Places a chosen opcode and operand bytes at the PC and runs it.
    task automatic run_bytes(bit [7:0] opc, bit [7:0] b1, bit [7:0] b2);
        bit [15:0] at;
        at = sb.pc;
        send(CMD_WRITE, at, opc);
        send(CMD_WRITE, at + 16'd1, b1);
        send(CMD_WRITE, at + 16'd2, b2);
        run_instruction();
    endtask

    task automatic wait_drained();
        quiet();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int        pick;
        bit [7:0]  opc;
        t_op       op;
        t_mode     mode;
        int        cyc;
        bit        hold_done, drain_done;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_EXEC;
        i_host_address = 16'h0000;
        i_host_data = 8'h00;
        i_out_stall = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        mode_left = 0;
        burst_left = 0;
        beats_sent = 0;
        idle_cycles = 0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: each flag case, the transfers, the shifts through
        // carry, the page and pointer wraps, an unknown opcode and the PC
        // wrapping round the top of memory.
        send(CMD_SETPC, 16'h0200, 8'h00);
        run_bytes(8'hA9, 8'h80, 8'h00);   // LDA #$80 sets N
        run_bytes(8'hA9, 8'h00, 8'h00);   // LDA #$00 sets Z
        run_bytes(8'hBA, 8'h00, 8'h00);   // TSX picks up the reset SP
        run_bytes(8'hA2, 8'hFF, 8'h00);   // LDX #$FF
        run_bytes(8'h9A, 8'h00, 8'h00);   // TXS leaves the flags alone
        run_bytes(8'hA0, 8'hFF, 8'h00);   // LDY #$FF
        run_bytes(8'h98, 8'h00, 8'h00);   // TYA
        run_bytes(8'h4A, 8'h00, 8'h00);   // LSR A clears N, sets C
        run_bytes(8'h6A, 8'h00, 8'h00);   // ROR A brings the carry in at the top
        run_bytes(8'h2A, 8'h00, 8'h00);   // ROL A
        run_bytes(8'h0A, 8'h00, 8'h00);   // ASL A
        run_bytes(8'hAA, 8'h00, 8'h00);   // TAX
        run_bytes(8'hA8, 8'h00, 8'h00);   // TAY
        run_bytes(8'h8A, 8'h00, 8'h00);   // TXA
        run_bytes(8'hB1, 8'hFF, 8'h00);   // LDA ($FF),Y: pointer wraps on page 0
        run_bytes(8'hA1, 8'h80, 8'h00);   // LDA ($80,X): sum wraps on page 0
        run_bytes(8'hBD, 8'hF0, 8'h12);   // LDA $12F0,X crosses a page
        run_bytes(8'h9D, 8'hF0, 8'h12);   // STA $12F0,X: no extra cycle
        run_bytes(8'h3E, 8'hFF, 8'hFF);   // ROL $FFFF,X wraps at 16 bits
        run_bytes(8'hB6, 8'h80, 8'h00);   // LDX $80,Y wraps on page 0
        run_bytes(8'h02, 8'h00, 8'h00);   // unknown opcode: nothing moves
        send(CMD_SETPC, 16'hFFFF, 8'hFF);
        run_bytes(8'hA9, 8'h5A, 8'h00);   // operand fetched from $0000
        send(CMD_WRITE, 16'h0000, 8'hFF);
        send(CMD_READ, 16'hFFFF, 8'h00);
        send(CMD_READ, 16'h0000, 8'hFF);

        // Random part: mostly whole instructions with random operands, with
        // unknown opcodes, host traffic and PC jumps mixed in.
        while (beats_sent < 1600) begin
            if (!hold_done && beats_sent > 500) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && beats_sent > 1000) begin
                wait_drained();
                drain_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                do begin
                    opc = 8'($urandom);
                    sb.decode(opc, op, mode, cyc);
                end while (op == OP_NONE);
                send(CMD_WRITE, sb.pc, opc);
                run_instruction();
            end else if (pick < 61) begin
                send(CMD_WRITE, sb.pc, 8'($urandom));
                run_instruction();
            end else if (pick < 70) begin
                run_instruction();
            end else if (pick < 80) begin
                send(CMD_WRITE, ($urandom_range(1) == 0) ? 16'($urandom_range(255)) :
                     16'($urandom), 8'($urandom));
            end else if (pick < 88 && sb.written_list.size() != 0) begin
                send(CMD_READ,
                     sb.written_list[$urandom_range(sb.written_list.size() - 1)],
                     8'($urandom));
            end else if (pick < 95) begin
                send(CMD_SETPC, 16'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 12)) quiet();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("tb: %0d beats sent, %0d instructions (%0d unknown opcodes, %0d with a",
                 beats_sent, sb.n_exec, sb.n_unsup, sb.n_cross);
        $display("tb: page-cross penalty), %0d host commands", sb.n_host);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
